### rtl/bsmr_pkg.sv
// bsmr_pkg: shared types and constants for the bounded stack with min and reverse
// depends on nothing; imported by every module of the block

package bsmr_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W = 5;
   localparam int BSMR_MAX_DEPTH = 16;
   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
   localparam logic signed [DATA_W-1:0] EMPTY_WORD = -32'sd1;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_PUSH    = 2'd1,
      KIND_POP     = 2'd2,
      KIND_REVERSE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_PUSH_FULL  = 2'd1,
      STATUS_POP_EMPTY  = 2'd2,
      STATUS_UNUSED     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_DONE
   } state_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [DATA_W-1:0]   push_value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [DATA_W-1:0]   popped_value;
      logic signed [DATA_W-1:0]   top_value;
      logic signed [DATA_W-1:0]   min_value;
      logic [CNT_W-1:0]           count;
      logic                       empty_res;
      logic                       full_res;
   } rsp_type;

   // control from the sequencer to the running-minimum unit
   typedef struct packed {
      logic clear;
      logic sample;
   } min_ctl_type;

endpackage

### rtl/bsmr_mem.sv
// bsmr_mem: stack entry storage, one write port and one read port, registered read
// depends on bsmr_pkg for the word width

module bsmr_mem
   import bsmr_pkg::*;
#(
   parameter int DEPTH  = BSMR_MAX_DEPTH,
   parameter int ADDR_W = $clog2(BSMR_MAX_DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bsmr_min_unit.sv
// bsmr_min_unit: signed compare unit keeping the running minimum of a scan
// depends on bsmr_pkg for the word width and the control struct

module bsmr_min_unit
   import bsmr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  min_ctl_type              ctl,
   input  logic signed [DATA_W-1:0] sample_data,
   output logic signed [DATA_W-1:0] min_value
);

   logic                     have_ff;
   logic                     have_in;
   logic signed [DATA_W-1:0] min_ff;
   logic signed [DATA_W-1:0] min_in;

   // first sample after clear is taken as is, later ones only when smaller
   always_comb begin
      have_in = have_ff;
      min_in  = min_ff;
      if (ctl.clear) begin
         have_in = 1'b0;
      end else if (ctl.sample) begin
         have_in = 1'b1;
         if (!have_ff || (sample_data < min_ff)) begin
            min_in = sample_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
   end

   assign min_value = min_ff;

endmodule

### rtl/bounded_stack_with_min_reverse.sv
// bounded_stack_with_min_reverse: top level, sequencer around entry memory and min unit
// depends on bsmr_pkg, bsmr_mem and bsmr_min_unit
//
// channel   ports                          transfer when
// request   start, busy, req_data          start high and busy low
// result    rsp_valid, rsp_data            rsp_valid high (one cycle, no backpressure)
// config    csr_valid, csr_ready, csr_data csr_valid and csr_ready high
//
// an item runs its push, pop read or reverse swaps (n/2 for n entries), then the minimum
// scan over the n entries it leaves (skipped when n is 0), then strobes the result
// the single read port sets the pace: the minimum scan reads one entry a cycle
// synchronous active-high reset clears count and state; capacity returns to 16
// busy is high from the cycle after a transfer until the result strobe
// the receiver cannot stall results; only busy holds off the next request

module bounded_stack_with_min_reverse
   import bsmr_pkg::*;
#(
   parameter int MAX_DEPTH = BSMR_MAX_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(MAX_DEPTH);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CNT_W-1:0]         cap_ff;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hi_ff, hi_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic                     scan_vld_ff;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] popped_ff, popped_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   logic signed [DATA_W-1:0] tmp_ff, tmp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic signed [DATA_W-1:0] rd_data;
   min_ctl_type              min_ctl;
   logic signed [DATA_W-1:0] min_value;
   logic                     full_now;

   // capacity above the physical depth acts as the depth
   assign full_now = (cnt_ff >= cap_ff) || (32'(cnt_ff) >= 32'(MAX_DEPTH));

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer: next state, memory port and min unit control
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      top_in       = top_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      min_ctl.clear  = 1'b0;
      min_ctl.sample = scan_vld_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               status_in = STATUS_DONE;
               popped_in = '0;
               state_in  = ST_SCAN_INIT;
               case (req_data.kind)
                  KIND_PUSH: begin
                     if (full_now) begin
                        status_in = STATUS_PUSH_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(cnt_ff);
                        wr_data = req_data.push_value;
                        cnt_in  = cnt_ff + 5'd1;
                     end
                  end
                  KIND_POP: begin
                     if (cnt_ff == '0) begin
                        status_in = STATUS_POP_EMPTY;
                     end else begin
                        cnt_in   = cnt_ff - 5'd1;
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(cnt_ff - 5'd1);
                        state_in = ST_POP_WAIT;
                     end
                  end
                  KIND_REVERSE: begin
                     lo_in = '0;
                     hi_in = cnt_ff - 5'd1;
                     if (cnt_ff >= 5'd2) begin
                        state_in = ST_REV_RD_LO;
                     end
                  end
                  default: begin
                     state_in = ST_SCAN_INIT;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            popped_in = rd_data;
            state_in  = ST_SCAN_INIT;
         end
         // one swap: read low, read high, write low, write high
         ST_REV_RD_LO: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(lo_ff);
            state_in = ST_REV_RD_HI;
         end
         ST_REV_RD_HI: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(hi_ff);
            tmp_in   = rd_data;
            state_in = ST_REV_WR_LO;
         end
         ST_REV_WR_LO: begin
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(lo_ff);
            wr_data  = rd_data;
            state_in = ST_REV_WR_HI;
         end
         ST_REV_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(hi_ff);
            wr_data = tmp_ff;
            lo_in   = lo_ff + 5'd1;
            hi_in   = hi_ff - 5'd1;
            if ((lo_ff + 5'd1) < (hi_ff - 5'd1)) begin
               state_in = ST_REV_RD_LO;
            end else begin
               state_in = ST_SCAN_INIT;
            end
         end
         // walk entries from the bottom, last one read is the top
         ST_SCAN_INIT: begin
            min_ctl.clear = 1'b1;
            idx_in        = '0;
            state_in      = (cnt_ff == '0) ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(idx_ff);
            idx_in  = idx_ff + 5'd1;
            if (idx_ff == (cnt_ff - 5'd1)) begin
               state_in = ST_SCAN_LAST;
            end
         end
         ST_SCAN_LAST: begin
            top_in   = rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.status       = status_ff;
            rsp_data_in.popped_value = popped_ff;
            rsp_data_in.top_value    = (cnt_ff == '0) ? EMPTY_WORD : top_ff;
            rsp_data_in.min_value    = (cnt_ff == '0) ? EMPTY_WORD : min_value;
            rsp_data_in.count        = cnt_ff;
            rsp_data_in.empty_res    = (cnt_ff == '0);
            rsp_data_in.full_res     = full_now;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= CAP_RESET;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scan_vld_ff  <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      top_ff      <= top_in;
      tmp_ff      <= tmp_in;
      rsp_data_ff <= rsp_data_in;
   end

   bsmr_mem #(
      .DEPTH  (MAX_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bsmr_min_unit u_min (
      .clock       (clock),
      .reset       (reset),
      .ctl         (min_ctl),
      .sample_data (rd_data),
      .min_value   (min_value)
   );

`ifndef SYNTHESIS
   // fill count never passes the physical depth
   assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= 32'(MAX_DEPTH))
      else $error("fill count above depth");

   // a transfer always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // result strobe comes in the cycle after the done state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_DONE) && (state_ff == ST_IDLE))
      else $error("result strobe out of sequence");

   // swap pointers stay ordered while reversing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REV_RD_LO) |-> (lo_ff < hi_ff) && (hi_ff < cnt_ff))
      else $error("swap pointers crossed");
`endif

endmodule
